// ===== rtl/tng_pkg.sv =====
// Package for the three-tone noise sound generator: widths, register codes,
// shared structs and the noise pattern table. No dependencies.

package tng_pkg;

  localparam int unsigned CTRL_W     = 8;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned STEP_W     = 9;
  localparam int unsigned VOLWORD_W  = VOL_W + STEP_W;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned NUM_TONE   = 3;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned SAMPLE_W   = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned NOISE_PERIOD = 8191;
  localparam int unsigned HIT_VALUE    = 'h80;
  localparam int unsigned SAMPLE_MAX   = 31139;

  // Divider pre-shift for low, mid, high tone and noise channels.
  localparam int unsigned PRE_SHIFT [NUM_CH] = '{2, 1, 0, 1};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_TONE      = 3'd0,
    REG_MID_TONE      = 3'd1,
    REG_HIGH_TONE     = 3'd2,
    REG_NOISE         = 3'd3,
    REG_MASTER_VOLUME = 3'd4,
    REG_VOLUME_STEP   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_CH-1:0][CTRL_W-1:0] ctrl;
    logic [VOL_W-1:0]              master_volume;
    logic [STEP_W-1:0]             volume_step;
  } cfg_t;

  typedef struct packed {
    logic [NUM_TONE-1:0] tone_bits;
    logic [POS_W-1:0]    noise_pos;
  } chan_next_t;

  // Noise pattern, eight bytes per row. The first byte of a row sits in the
  // top eight bits, so the bit for a position is {~pos[5:3], pos[2:0]}.
  function automatic logic [63:0] noise_row(input logic [6:0] row);
    logic [63:0] r;
    case (row)
      7'd0:   r = 64'h071e1e1c1c3e3c38;
      7'd1:   r = 64'h78f87c1e1f8f0707;
      7'd2:   r = 64'hc1c0e0f1e0f0e3e1;
      7'd3:   r = 64'hc0e0787e3c38e0e1;
      7'd4:   r = 64'hc3c387c7071e1c1f;
      7'd5:   r = 64'h0e0e1e0e0f0fc3c3;
      7'd6:   r = 64'hf1e1e3c1e3c3c3fc;
      7'd7:   r = 64'h3c1e0f83c3c1c1c3;
      7'd8:   r = 64'hc3c78787c70f0e3c;
      7'd9:   r = 64'h7c783c3c3c383e1c;
      7'd10:  r = 64'h7c1e3c0f0e3e78f0;
      7'd11:  r = 64'hf0e0e1f1c1c3c7c3;
      7'd12:  r = 64'he1f1e0e1f0f1e3c0;
      7'd13:  r = 64'hf0e0f870e38787c0;
      7'd14:  r = 64'hf0e0f1e1e1c78387;
      7'd15:  r = 64'h838f8787c783c383;
      7'd16:  r = 64'hc3f1e1c3c781cf87;
      7'd17:  r = 64'h0387c7c78783e1c3;
      7'd18:  r = 64'h07c387870787c387;
      7'd19:  r = 64'h83e1c3c7c387878f;
      7'd20:  r = 64'h0f87870fcf1f878e;
      7'd21:  r = 64'h0e0781c3e3c1e0f0;
      7'd22:  r = 64'he0e3838707878e1e;
      7'd23:  r = 64'h0f07878f1f0787c1;
      7'd24:  r = 64'hf0e1e1e3c70f038f;
      7'd25:  r = 64'h870e1e1e0f87870f;
      7'd26:  r = 64'h871f0fc3c3f0f8f0;
      7'd27:  r = 64'h70f1f0f0e1f0e078;
      7'd28:  r = 64'h7c787c7071e1e1c3;
      7'd29:  r = 64'hc3c7871c3c3c1c3c;
      7'd30:  r = 64'h7c1e1e1e1c3c78f8;
      7'd31:  r = 64'hf8e1c3871e1e3c3e;
      7'd32:  r = 64'h0f0f871f8e0f0f8e;
      7'd33:  r = 64'h1e1e1e1e0f0f8f87;
      7'd34:  r = 64'h87c383c1e1c3c1c3;
      7'd35:  r = 64'hc78f0f0f0f0f83c7;
      7'd36:  r = 64'hc3c1e1e0f83e3c3c;
      7'd37:  r = 64'h3c3c3c783e1e1e1e;
      7'd38:  r = 64'h0f0f0f1e0e1e1e0f;
      7'd39:  r = 64'h0f871f87871c3e1f;
      7'd40:  r = 64'h0f0f8e3e0e3e1e1c;
      7'd41:  r = 64'h3c7cfc3878783878;
      7'd42:  r = 64'h70f87c1e3c3c30f1;
      7'd43:  r = 64'hf07070e0f8f0f878;
      7'd44:  r = 64'h7871e1f0e3c1f071;
      7'd45:  r = 64'he3c7878e3e0e1e3e;
      7'd46:  r = 64'h0f07870c3e0f870f;
      7'd47:  r = 64'h1e3c3c3878f1e7c3;
      7'd48:  r = 64'hc3c78e3c38f0e07e;
      7'd49:  r = 64'h1e3e0e0f0f0f03c3;
      7'd50:  r = 64'hc3c7871f0e1e1c3c;
      7'd51:  r = 64'h3c0f0707c7c78787;
      7'd52:  r = 64'h8f0fc0f0f860f0f0;
      7'd53:  r = 64'he1e3e3c3c3c3870f;
      7'd54:  r = 64'h878e1e1e3f1e0e1c;
      7'd55:  r = 64'h3c7e1e3c38787878;
      7'd56:  r = 64'h38783ce1e38f1f1c;
      7'd57:  r = 64'h78707e0f8707c3c7;
      7'd58:  r = 64'h0f1e3c0e0f0e1e03;
      7'd59:  r = 64'hf0f0f1e3c1c7c0e1;
      7'd60:  r = 64'he1e1e1e070e1f078;
      7'd61:  r = 64'h70e3c70fc1e1e3c3;
      7'd62:  r = 64'hc0f0fc1c3c70f870;
      7'd63:  r = 64'hf8783c70f078707c;
      7'd64:  r = 64'h7c3c381e3e3c7e07;
      7'd65:  r = 64'h83c7c1c1e1c3c3c3;
      7'd66:  r = 64'he1e1f0787c3e0f1f;
      7'd67:  r = 64'h078f0f8387c1e3e3;
      7'd68:  r = 64'hc3c3e1f0f8f03c7c;
      7'd69:  r = 64'h3c0f8e0e1f1f0e3c;
      7'd70:  r = 64'h38787070f0f0f870;
      7'd71:  r = 64'h7078383c70e0f078;
      7'd72:  r = 64'hf1f0783e3c0f070e;
      7'd73:  r = 64'h3e1e3f1e0e0f8787;
      7'd74:  r = 64'h070f07c78f0f871e;
      7'd75:  r = 64'h1e1f1e1e3c1e1c3e;
      7'd76:  r = 64'h0f03c381e0f0fc38;
      7'd77:  r = 64'h3c3e0e1e1c7c1e1f;
      7'd78:  r = 64'h0e3e1c78787c1e3e;
      7'd79:  r = 64'h1e3c1f0f1f0f0f8f;
      7'd80:  r = 64'h1c3c78f8f0f870f0;
      7'd81:  r = 64'h78783c3c783c1f0f;
      7'd82:  r = 64'h07861c1e1c1e1e1f;
      7'd83:  r = 64'h03c3c78e3c3c1c18;
      7'd84:  r = 64'hf0e1c3e1c1e1e3c3;
      7'd85:  r = 64'hc3e3c3838783870f;
      7'd86:  r = 64'h0707e1e1e07c7838;
      7'd87:  r = 64'h78783c1f0f8f0e07;
      7'd88:  r = 64'h0f0783c3c381f0f8;
      7'd89:  r = 64'hf1e0e3c71c3e1e0f;
      7'd90:  r = 64'h0fc3f0f0e383c3c7;
      7'd91:  r = 64'h070f0f0f0f0f0787;
      7'd92:  r = 64'h0f0f0e0f0f1e0f0f;
      7'd93:  r = 64'h8787878fc7c78383;
      7'd94:  r = 64'hc3c78f8707c38e1e;
      7'd95:  r = 64'h383e3c387c1f1c38;
      7'd96:  r = 64'h3c787c1e1c3c3f1e;
      7'd97:  r = 64'h0e3e1c3c1f0f07c3;
      7'd98:  r = 64'he3838781c1e3cf0e;
      7'd99:  r = 64'h0f1e3e1e1f0f8fc3;
      7'd100: r = 64'h870e03f0f070e0e1;
      7'd101: r = 64'he1c78e0f0f1e0e1e;
      7'd102: r = 64'h1f1c78f0f1f1e0f1;
      7'd103: r = 64'he1e1e0e0f1c1f071;
      7'd104: r = 64'he1c383c783e1e1f8;
      7'd105: r = 64'h70f0f0f0f0f070f8;
      7'd106: r = 64'h707061e0f0e1e078;
      7'd107: r = 64'h71e0f0f8381e1c38;
      7'd108: r = 64'h70f86078383c3f1f;
      7'd109: r = 64'h0f1f0f1f87878387;
      7'd110: r = 64'h83e1e1f078f1f070;
      7'd111: r = 64'h383870e0e3c0e0f8;
      7'd112: r = 64'h7878f838f1e1e1c3;
      7'd113: r = 64'h87870e1e1f0e0e0f;
      7'd114: r = 64'h0f87c3870783c0f0;
      7'd115: r = 64'h383c3c38f0fc3e1e;
      7'd116: r = 64'h1c1c3870f0f1e0f0;
      7'd117: r = 64'he0e0f1e3e0e1f0f0;
      7'd118: r = 64'h787c783c78783878;
      7'd119: r = 64'h78787870e38383e0;
      7'd120: r = 64'hc3c1e1c1c1c1e3c3;
      7'd121: r = 64'hc71e0e1f1e1e0f0f;
      7'd122: r = 64'h0e0e0e078387870e;
      7'd123: r = 64'h078f0f0f0f0e1c70;
      7'd124: r = 64'he1e071c18383870f;
      7'd125: r = 64'h1e1878787c3e1c38;
      7'd126: r = 64'hf0e1e07870383c3e;
      7'd127: r = 64'h1e3c1e1c703c383f;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tng_if.sv =====
// Handshake channel interfaces for the three-tone noise sound generator.
// Depends on tng_pkg for field widths.

interface tng_in_if;
  import tng_pkg::*;
  logic valid;
  logic ready;
  logic sample_wanted;
  modport source (output valid, output sample_wanted, input ready);
  modport sink   (input valid, input sample_wanted, output ready);
endinterface

interface tng_out_if;
  import tng_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tng_cfg_if;
  import tng_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tng_channels.sv =====
// Divider counters, tone shift registers and noise position of the generator.
// Depends on tng_pkg; advances one tick per accepted item.

module tng_channels
  import tng_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  cfg_t       cfg_i,
  output chan_next_t next_o
);

  logic [NUM_CH-1:0][CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_CH-1:0]              fire;
  logic [NUM_TONE-1:0][CTRL_W-1:0] shft_q, shft_d;
  logic [POS_W-1:0]               pos_q, pos_d;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_div
    localparam int unsigned SH = PRE_SHIFT[g];
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] reload;

    assign cnt_inc = cnt_q[g] + CNT_W'(1);
    assign reload  = CNT_W'(cfg_i.ctrl[g][CTRL_W-2:0]) << SH;
    assign fire[g] = ((cnt_inc >> SH) == CNT_W'(HIT_VALUE));

    always_comb begin
      cnt_d[g] = cnt_q[g];
      if (tick_i) begin
        cnt_d[g] = fire[g] ? reload : cnt_inc;
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NUM_TONE; t++) begin
      shft_d[t] = shft_q[t];
      // The fed-back bit is the inverted top bit, gated by the enable bit.
      if (tick_i && fire[t]) begin
        shft_d[t] = {shft_q[t][CTRL_W-2:0],
                     ~shft_q[t][CTRL_W-1] & cfg_i.ctrl[t][CTRL_W-1]};
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (tick_i && fire[NUM_CH-1]) begin
      pos_d = (pos_q == POS_W'(NOISE_PERIOD - 1)) ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      shft_q <= '0;
      pos_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      shft_q <= shft_d;
      pos_q  <= pos_d;
    end
  end

  always_comb begin
    for (int t = 0; t < NUM_TONE; t++) begin
      next_o.tone_bits[t] = shft_d[t][0];
    end
    next_o.noise_pos = pos_d;
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != POS_W'(NOISE_PERIOD))
    else $error("noise position left its period");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_i |=> ($stable(pos_q) && $stable(shft_q) && $stable(cnt_q)))
    else $error("channel state moved without a tick");

endmodule

// ===== rtl/tng_mixer.sv =====
// Two-stage mixer: captures channel bits and the volume word, then looks up
// the noise bit and forms the sample in the output register. Uses tng_pkg.

module tng_mixer
  import tng_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                want_i,
  input  chan_next_t          next_i,
  input  cfg_t                cfg_i,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] sample_o
);

  logic                 s1_valid_q;
  logic [1:0]           s1_tones_q, s1_tones_d;
  logic [POS_W-1:0]     s1_pos_q;
  logic                 s1_noise_en_q;
  logic [VOLWORD_W-1:0] s1_vol_q, s1_vol_d;

  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  sample_q, sample_d;

  logic [63:0]          row;
  logic                 noise_bit;
  logic [2:0]           bits;
  logic [SAMPLE_W-1:0]  vol_ext;

  assign s1_tones_d = {1'b0, next_i.tone_bits[0]} + {1'b0, next_i.tone_bits[1]}
                    + {1'b0, next_i.tone_bits[2]};
  assign s1_vol_d   = VOLWORD_W'(cfg_i.master_volume) * VOLWORD_W'(cfg_i.volume_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q  <= want_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_tones_q    <= s1_tones_d;
      s1_pos_q      <= next_i.noise_pos;
      s1_noise_en_q <= cfg_i.ctrl[NUM_CH-1][CTRL_W-1];
      s1_vol_q      <= s1_vol_d;
      sample_q      <= sample_d;
    end
  end

  // The table row holds 64 positions; the first byte sits at the top.
  assign row       = noise_row(s1_pos_q[POS_W-1:6]);
  assign noise_bit = row[{~s1_pos_q[5:3], s1_pos_q[2:0]}] & s1_noise_en_q;
  assign bits      = {1'b0, s1_tones_q} + {2'b00, noise_bit};
  assign vol_ext   = SAMPLE_W'(s1_vol_q);

  // Bit count times volume word by shift and add, plus the offset term.
  assign sample_d = (bits[0] ? vol_ext : '0)
                  + (bits[1] ? (vol_ext << 1) : '0)
                  + (bits[2] ? (vol_ext << 2) : '0)
                  + (vol_ext >> 4);

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && s1_valid_q) |=> out_valid_q)
    else $error("captured item did not reach the output register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(s1_valid_q) && $stable(out_valid_q)))
    else $error("pipeline moved during a stall");

  a_sample_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_q <= SAMPLE_W'(SAMPLE_MAX)))
    else $error("sample above its range");

endmodule

// ===== rtl/three_tone_noise_sound_generator.sv =====
// Top level of the three-tone noise sound generator: configuration registers
// and channel handshake. Depends on tng_pkg, tng_if, tng_channels, tng_mixer.
//
// Usage: every item on in_i is one sample tick. All four channel dividers
// count once per item; the three tone shifters and the noise position step
// on their divider's hit. An item with sample_wanted set produces one item on
// out_o holding the mixed sample; an item with it clear produces nothing.
// cfg_i writes register index 0..5 (low, mid, high tone control, noise
// control, master volume, volume step); other indexes are ignored. It is
// always ready and must only be used while no item is in flight.
// An accepted item is captured in the first stage register, then loaded
// into the output register, from which it is valid on out_o. Throughput
// is one item per cycle while out_o does not stall, set by the two-register
// pipeline with no loop across it.
// Reset clears config, counters, shifters, noise position and valid flags.
// When out_o stalls with a sample waiting, the whole pipeline holds and
// in_i.ready drops until the sample is taken.

module three_tone_noise_sound_generator
  import tng_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tng_in_if.sink    in_i,
  tng_out_if.source out_o,
  tng_cfg_if.sink   cfg_i
);

  cfg_t       cfg_q, cfg_d;
  chan_next_t chan_next;
  logic       advance;
  logic       out_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LOW_TONE:      cfg_d.ctrl[0]       = cfg_i.data[CTRL_W-1:0];
        REG_MID_TONE:      cfg_d.ctrl[1]       = cfg_i.data[CTRL_W-1:0];
        REG_HIGH_TONE:     cfg_d.ctrl[2]       = cfg_i.data[CTRL_W-1:0];
        REG_NOISE:         cfg_d.ctrl[3]       = cfg_i.data[CTRL_W-1:0];
        REG_MASTER_VOLUME: cfg_d.master_volume = cfg_i.data[VOL_W-1:0];
        REG_VOLUME_STEP:   cfg_d.volume_step   = cfg_i.data[STEP_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  assign advance     = !out_valid || out_o.ready;
  assign in_i.ready  = advance;
  assign out_o.valid = out_valid;

  tng_channels u_channels (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (in_i.valid && advance),
    .cfg_i  (cfg_q),
    .next_o (chan_next)
  );

  tng_mixer u_mixer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (advance),
    .want_i      (in_i.valid && in_i.sample_wanted),
    .next_i      (chan_next),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid),
    .sample_o    (out_o.sample)
  );

endmodule
